FILE: rtl/core/kst_pkg.sv
// Shared types, character codes and UTF-8 helper functions for the
// Korean spacing text filter. No dependencies; every other file imports it.

package kst_pkg;

    typedef logic [20:0] cp_t;

    // Code points used by the spacing rules.
    localparam cp_t CP_REPL   = 21'h00FFFD;
    localparam cp_t CP_SPACE  = 21'h000020;
    localparam cp_t CP_DOT    = 21'h00002E;
    localparam cp_t CP_BANG   = 21'h000021;
    localparam cp_t CP_QUEST  = 21'h00003F;
    localparam cp_t CP_COLON  = 21'h00003A;
    localparam cp_t CP_STAR   = 21'h00002A;
    localparam cp_t CP_RBRACK = 21'h00005D;
    localparam cp_t CP_RPAREN = 21'h000029;
    localparam cp_t CP_RBRACE = 21'h00007D;
    localparam cp_t CP_LBRACK = 21'h00005B;
    localparam cp_t CP_LPAREN = 21'h000028;
    localparam cp_t CP_LBRACE = 21'h00007B;

    localparam logic [7:0] BYTE_SPACE = 8'h20;

    // UTF-8 byte tags.
    localparam logic [1:0] TAG_CONT  = 2'b10;
    localparam logic [2:0] TAG_LEAD2 = 3'b110;
    localparam logic [3:0] TAG_LEAD3 = 4'b1110;
    localparam logic [4:0] TAG_LEAD4 = 5'b11110;

    // Code points completed by one input byte, in order.
    typedef struct packed {
        logic [1:0]      count;
        cp_t [2:0]       cp;
    } cp_list_t;

    // One emitted code point, with an optional trailing space.
    typedef struct packed {
        logic present;
        logic space;
        cp_t  cp;
    } seg_t;

    // Total sequence length for a lead byte; zero for a byte that cannot lead.
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == TAG_LEAD2) begin
            len = 3'd2;
        end else if (b[7:4] == TAG_LEAD3) begin
            len = 3'd3;
        end else if (b[7:3] == TAG_LEAD4) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    // Lone byte at the end of a text: ASCII stays, anything else is replaced.
    function automatic cp_t single_last(input logic [7:0] b);
        return (b[7] == 1'b0) ? {13'd0, b} : CP_REPL;
    endfunction

    function automatic logic hangul(input cp_t cp);
        return (cp >= 21'h00AC00 && cp <= 21'h00D7AF) ||
               (cp >= 21'h001100 && cp <= 21'h0011FF) ||
               (cp >= 21'h003130 && cp <= 21'h00318F);
    endfunction

    // Encoded length minus one, shortest form.
    function automatic logic [1:0] enc_lenm1(input cp_t cp);
        logic [1:0] l;
        if (cp < 21'h000080) begin
            l = 2'd0;
        end else if (cp < 21'h000800) begin
            l = 2'd1;
        end else if (cp < 21'h010000) begin
            l = 2'd2;
        end else begin
            l = 2'd3;
        end
        return l;
    endfunction

    // Byte k of the shortest UTF-8 encoding of cp.
    function automatic logic [7:0] enc_byte(input cp_t cp, input logic [1:0] lenm1,
                                            input logic [1:0] k);
        logic [7:0] b;
        unique case (lenm1)
            2'd0: b = cp[7:0];
            2'd1: b = (k == 2'd0) ? {TAG_LEAD2, cp[10:6]} : {TAG_CONT, cp[5:0]};
            2'd2: begin
                unique case (k)
                    2'd0:    b = {TAG_LEAD3, cp[15:12]};
                    2'd1:    b = {TAG_CONT, cp[11:6]};
                    default: b = {TAG_CONT, cp[5:0]};
                endcase
            end
            default: begin
                unique case (k)
                    2'd0:    b = {TAG_LEAD4, cp[20:18]};
                    2'd1:    b = {TAG_CONT, cp[17:12]};
                    2'd2:    b = {TAG_CONT, cp[11:6]};
                    default: b = {TAG_CONT, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/kst_decode.sv
// UTF-8 decoder: keeps the bytes of an unfinished sequence and turns each
// input byte into zero to three code points. Depends on kst_pkg.

module kst_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output kst_pkg::cp_list_t cps
);
    import kst_pkg::*;

    logic [7:0]      pend_reg [3];
    logic [1:0]      pend_cnt_reg, pend_cnt_next;
    logic [1:0]      extra_reg, extra_next;
    logic            wr_en;
    logic [3:0][7:0] bytes;
    logic [2:0]      lead_len;
    logic [2:0]      r0_len;
    cp_t             full_cp;
    cp_t             pair_cp;

    always_comb begin
        bytes = {8'h00, pend_reg[2], pend_reg[1], pend_reg[0]};
        bytes[pend_cnt_reg] = in_byte;
        lead_len = seq_len(in_byte);
        r0_len   = seq_len(bytes[1]);
        pair_cp  = {10'd0, bytes[1][4:0], bytes[2][5:0]};
        unique case (extra_reg)
            2'd1:    full_cp = {10'd0, bytes[0][4:0], bytes[1][5:0]};
            2'd2:    full_cp = {5'd0, bytes[0][3:0], bytes[1][5:0], bytes[2][5:0]};
            2'd3:    full_cp = {bytes[0][2:0], bytes[1][5:0], bytes[2][5:0],
                                bytes[3][5:0]};
            default: full_cp = {13'd0, bytes[0]};
        endcase
    end

    always_comb begin
        cps           = '0;
        pend_cnt_next = pend_cnt_reg;
        extra_next    = extra_reg;
        wr_en         = 1'b0;
        if (pend_cnt_reg == 2'd0) begin
            if (lead_len == 3'd0) begin
                cps.count  = 2'd1;
                cps.cp[0]  = CP_REPL;
            end else if (lead_len == 3'd1) begin
                cps.count  = 2'd1;
                cps.cp[0]  = {13'd0, in_byte};
            end else if (in_last) begin
                cps.count  = 2'd1;
                cps.cp[0]  = CP_REPL;
            end else begin
                wr_en         = 1'b1;
                pend_cnt_next = 2'd1;
                extra_next    = 2'(lead_len - 3'd1);
            end
        end else if (pend_cnt_reg == extra_reg) begin
            cps.count     = 2'd1;
            cps.cp[0]     = full_cp;
            pend_cnt_next = 2'd0;
            extra_next    = 2'd0;
        end else if (!in_last) begin
            wr_en         = 1'b1;
            pend_cnt_next = pend_cnt_reg + 2'd1;
        end else begin
            // The text ends inside a sequence: the lead is replaced and the
            // bytes behind it are decoded again on their own.
            cps.cp[0] = CP_REPL;
            if (r0_len == 3'd2 && pend_cnt_reg == 2'd2) begin
                cps.count = 2'd2;
                cps.cp[1] = pair_cp;
            end else begin
                cps.cp[1] = single_last(bytes[1]);
                if (pend_cnt_reg == 2'd2) begin
                    cps.count = 2'd3;
                    cps.cp[2] = single_last(bytes[2]);
                end else begin
                    cps.count = 2'd2;
                end
            end
        end
        if (in_last) begin
            pend_cnt_next = 2'd0;
            extra_next    = 2'd0;
            wr_en         = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cnt_reg <= 2'd0;
            extra_reg    <= 2'd0;
        end else if (step) begin
            pend_cnt_reg <= pend_cnt_next;
            extra_reg    <= extra_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && wr_en) begin
            pend_reg[pend_cnt_reg] <= in_byte;
        end
    end

    a_one_cp_mid_text: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !in_last |-> cps.count <= 2'd1)
        else $error("more than one code point completed by a byte inside the text");

    a_pend_below_need: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_cnt_reg != 2'd0 |-> (extra_reg != 2'd0 && pend_cnt_reg <= extra_reg))
        else $error("pending byte count exceeds the sequence length");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_last |=> pend_cnt_reg == 2'd0 && extra_reg == 2'd0)
        else $error("pending sequence survived the end of a text");

endmodule

FILE: rtl/core/kst_rules.sv
// Spacing rules: holds the previous code point and turns each new code point
// into up to four output segments in parallel lanes. Depends on kst_pkg.

module kst_rules (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic               in_last,
    input  kst_pkg::cp_list_t  cps,
    output kst_pkg::seg_t [3:0] segs
);
    import kst_pkg::*;

    cp_t  held_cp_reg;
    logic held_valid_reg;
    logic bef_dot_reg;

    cp_t  prev [3];
    logic pv   [3];
    logic bd   [3];
    cp_t  last_cp;

    function automatic logic ins_space(input cp_t cur, input cp_t nxt, input logic bdot);
        logic after_punct;
        logic before_open;
        after_punct = (cur == CP_BANG) || (cur == CP_QUEST) ||
                      (cur == CP_DOT && !bdot) ||
                      (cur == CP_RBRACK) || (cur == CP_RPAREN) || (cur == CP_RBRACE) ||
                      (cur == CP_COLON) || (cur == CP_STAR);
        before_open = (nxt == CP_LBRACK) || (nxt == CP_LPAREN) || (nxt == CP_LBRACE);
        return (nxt != CP_SPACE) &&
               ((hangul(nxt) && after_punct) || (hangul(cur) && before_open));
    endfunction

    always_comb begin
        prev[0] = held_cp_reg;
        pv[0]   = held_valid_reg;
        bd[0]   = bef_dot_reg;
        prev[1] = cps.cp[0];
        pv[1]   = 1'b1;
        bd[1]   = held_valid_reg && (held_cp_reg == CP_DOT);
        prev[2] = cps.cp[1];
        pv[2]   = 1'b1;
        bd[2]   = (cps.cp[0] == CP_DOT);

        for (int k = 0; k < 3; k++) begin
            segs[k].cp      = prev[k];
            segs[k].present = (2'(k) < cps.count) && pv[k] &&
                              !(prev[k] == CP_SPACE && cps.cp[k] == CP_SPACE);
            segs[k].space   = ins_space(prev[k], cps.cp[k], bd[k]);
        end

        unique case (cps.count)
            2'd0:    last_cp = held_cp_reg;
            2'd1:    last_cp = cps.cp[0];
            2'd2:    last_cp = cps.cp[1];
            default: last_cp = cps.cp[2];
        endcase

        // The end of a text flushes the newest code point unchanged.
        segs[3].cp      = last_cp;
        segs[3].space   = 1'b0;
        segs[3].present = in_last && (cps.count != 2'd0 || held_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cp_reg    <= '0;
            held_valid_reg <= 1'b0;
            bef_dot_reg    <= 1'b0;
        end else if (step) begin
            if (in_last) begin
                held_cp_reg    <= '0;
                held_valid_reg <= 1'b0;
                bef_dot_reg    <= 1'b0;
            end else if (cps.count != 2'd0) begin
                held_cp_reg    <= cps.cp[0];
                held_valid_reg <= 1'b1;
                bef_dot_reg    <= bd[1];
            end
        end
    end

endmodule

FILE: rtl/core/kst_emit.sv
// Output serializer: registers the segments of one input byte and walks
// them out one UTF-8 byte per transaction. Depends on kst_pkg.

module kst_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  kst_pkg::seg_t [3:0] segs,
    input  logic                text_end,
    output logic                can_load,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);
    import kst_pkg::*;

    cp_t        seg_cp_reg    [4];
    logic [1:0] seg_lenm1_reg [4];
    logic       seg_sp_reg    [4];
    logic [3:0] mask_reg;
    logic       end_reg;
    logic [2:0] pos_reg;

    logic [1:0] cur;
    logic [2:0] total_m1;
    logic       at_seg_end;
    logic [3:0] rest;
    logic       final_byte;
    logic       xfer;

    always_comb begin
        cur = 2'd0;
        for (int k = 3; k >= 0; k--) begin
            if (mask_reg[k]) begin
                cur = 2'(k);
            end
        end
        total_m1   = {1'b0, seg_lenm1_reg[cur]} + {2'b00, seg_sp_reg[cur]};
        at_seg_end = (pos_reg == total_m1);
        rest       = mask_reg & ~(4'b0001 << cur);
        final_byte = at_seg_end && (rest == 4'd0);
        m_tvalid   = (mask_reg != 4'd0);
        xfer       = m_tvalid && m_tready;
        can_load   = (mask_reg == 4'd0) || (m_tready && final_byte);
        if (pos_reg <= {1'b0, seg_lenm1_reg[cur]}) begin
            m_tdata = enc_byte(seg_cp_reg[cur], seg_lenm1_reg[cur], pos_reg[1:0]);
        end else begin
            m_tdata = BYTE_SPACE;
        end
        m_tlast = final_byte;
        m_tuser = final_byte && end_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 4'd0;
            pos_reg  <= 3'd0;
        end else if (load) begin
            mask_reg <= {segs[3].present, segs[2].present, segs[1].present,
                         segs[0].present};
            pos_reg  <= 3'd0;
        end else if (xfer) begin
            if (at_seg_end) begin
                mask_reg <= rest;
                pos_reg  <= 3'd0;
            end else begin
                pos_reg  <= pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < 4; k++) begin
                seg_cp_reg[k]    <= segs[k].cp;
                seg_lenm1_reg[k] <= enc_lenm1(segs[k].cp);
                seg_sp_reg[k]    <= segs[k].space;
            end
            end_reg <= text_end;
        end
    end

    a_pos_in_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pos_reg <= total_m1)
        else $error("byte position ran past the current segment");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_tvalid)
        else $error("loaded segments produced no output transaction");

endmodule

FILE: rtl/core/korean_spacing_text_filter.sv
// Korean spacing text filter, top level. An accepted byte is decoded from the input
// register, and its segments are registered in the output serializer before they are
// offered. Throughput: one input byte per cycle while each byte releases at most one
// output byte and the output is not stalled; a byte that releases more keeps the output
// serializer busy until all of them are taken. Reset (aresetn, synchronous, active low)
// empties the input register, the pending sequence and the held point.
// Depends on kst_pkg, kst_decode, kst_rules and kst_emit.

module korean_spacing_text_filter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // text_end
);
    import kst_pkg::*;

    // Input register: one transaction waits here while the decoder and the
    // spacing rules work on it combinationally.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    cp_list_t   cps;
    seg_t [3:0] segs;
    logic       any_seg;
    logic       can_load;
    logic       step;
    logic       load;

    // A byte that yields no segment retires at once; a byte that yields output
    // waits until the serializer can take its segments: when it is empty, or in the
    // same cycle as the last byte of the previous run is taken.
    assign any_seg  = segs[0].present | segs[1].present | segs[2].present |
                      segs[3].present;
    assign step     = in_valid_reg && (!any_seg || can_load);
    assign load     = step && any_seg;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    kst_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .cps     (cps)
    );

    // The held code point goes out only once its successor is known, since
    // both space collapsing and space insertion look one code point ahead.
    kst_rules u_rules (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_last (in_last_reg),
        .cps     (cps),
        .segs    (segs)
    );

    kst_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .segs     (segs),
        .text_end (in_last_reg),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: sim/kst_text_checker.sv
// Scoreboard for the Korean spacing text filter: watches both stream channels, predicts
// the rewritten text from every accepted input byte and compares it with the output.
// Depends on kst_pkg for the code point type, the punctuation codes and the UTF-8 tags.

module kst_text_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,     // in_byte
    input  logic        s_tlast,     // in_last
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,     // out_byte
    input  logic        m_tlast,     // run_last
    input  logic        m_tuser,     // text_end
    output int unsigned mismatches,
    output int unsigned bytes_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import kst_pkg::*;

    localparam cp_t SYLLABLE_FIRST = 21'h00AC00;
    localparam cp_t SYLLABLE_LAST  = 21'h00D7AF;
    localparam cp_t JAMO_FIRST     = 21'h001100;
    localparam cp_t JAMO_LAST      = 21'h0011FF;
    localparam cp_t COMPAT_FIRST   = 21'h003130;
    localparam cp_t COMPAT_LAST    = 21'h00318F;

    localparam int MAX_BYTES_PER_INPUT = 16;
    localparam int REPORT_LIMIT        = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_end;
    } text_byte_t;

    // Rewritten bytes still due on the output, oldest first.
    text_byte_t owed_q[$];
    // Bytes released by the input byte being predicted.
    logic [7:0] step_q[$];

    // Decoder and spacing state.
    logic [7:0]  seq_buf[3];
    int unsigned seq_fill;
    cp_t         held_cp;
    logic        held_ok;
    logic        held_after_dot;

    int unsigned fail_total;
    int unsigned result_index;

    function automatic int unsigned utf8_span(input logic [7:0] lead);
        if (lead < 8'h80) return 1;
        if (lead < 8'hC0) return 0;
        if (lead < 8'hE0) return 2;
        if (lead < 8'hF0) return 3;
        if (lead < 8'hF8) return 4;
        return 0;
    endfunction

    function automatic logic hangul_point(input cp_t cp);
        return (cp >= SYLLABLE_FIRST && cp <= SYLLABLE_LAST) ||
               (cp >= JAMO_FIRST && cp <= JAMO_LAST) ||
               (cp >= COMPAT_FIRST && cp <= COMPAT_LAST);
    endfunction

    function automatic void push_step(input logic [7:0] b);
        if (step_q.size() < MAX_BYTES_PER_INPUT) step_q.insert(step_q.size(), b);
    endfunction

    function automatic void push_utf8(input cp_t cp);
        if (cp < 21'h000080) begin
            push_step(cp[7:0]);
        end else if (cp < 21'h000800) begin
            push_step({TAG_LEAD2, cp[10:6]});
            push_step({TAG_CONT, cp[5:0]});
        end else if (cp < 21'h010000) begin
            push_step({TAG_LEAD3, cp[15:12]});
            push_step({TAG_CONT, cp[11:6]});
            push_step({TAG_CONT, cp[5:0]});
        end else begin
            push_step({TAG_LEAD4, cp[20:18]});
            push_step({TAG_CONT, cp[17:12]});
            push_step({TAG_CONT, cp[11:6]});
            push_step({TAG_CONT, cp[5:0]});
        end
    endfunction

    // The held code point goes out once its successor is known.
    function automatic void release_held(input cp_t cur, input cp_t nxt);
        logic gap;
        gap = 1'b0;
        if (cur == CP_SPACE && nxt == CP_SPACE) return;
        push_utf8(cur);
        if (nxt == CP_SPACE) return;
        if (hangul_point(nxt)) begin
            if (cur == CP_BANG || cur == CP_QUEST || cur == CP_COLON || cur == CP_STAR ||
                cur == CP_RBRACK || cur == CP_RPAREN || cur == CP_RBRACE) gap = 1'b1;
            // A dot that closes an ellipsis gets no space.
            if (cur == CP_DOT && !held_after_dot) gap = 1'b1;
        end
        if (hangul_point(cur) && (nxt == CP_LBRACK || nxt == CP_LPAREN || nxt == CP_LBRACE))
            gap = 1'b1;
        if (gap) push_step(BYTE_SPACE);
    endfunction

    function automatic void take_point(input cp_t cp);
        logic was_dot;
        was_dot = 1'b0;
        if (held_ok) begin
            release_held(held_cp, cp);
            was_dot = (held_cp == CP_DOT);
        end
        held_after_dot = was_dot;
        held_cp        = cp;
        held_ok        = 1'b1;
    endfunction

    function automatic void clear_text();
        seq_fill       = 0;
        held_cp        = '0;
        held_ok        = 1'b0;
        held_after_dot = 1'b0;
        foreach (seq_buf[i]) seq_buf[i] = 8'h00;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic fin);
        logic [7:0]  window[4];
        int unsigned fill;
        int unsigned pos;
        int unsigned span;
        int unsigned k;
        logic        stuck;
        cp_t         cp;
        text_byte_t  beat;
        for (k = 0; k < 3; k++) window[k] = seq_buf[k];
        window[seq_fill] = b;
        fill  = seq_fill + 1;
        pos   = 0;
        stuck = 1'b0;
        step_q.delete();
        while (pos < fill && !stuck) begin
            span = utf8_span(window[pos]);
            if (span == 0) begin
                take_point(CP_REPL);
                pos++;
            end else if (pos + span <= fill) begin
                // Continuation bytes are taken as they come, low six bits only.
                case (span)
                    1:       cp = {13'd0, window[pos]};
                    2:       cp = {16'd0, window[pos][4:0]};
                    3:       cp = {17'd0, window[pos][3:0]};
                    default: cp = {18'd0, window[pos][2:0]};
                endcase
                for (k = 1; k < span; k++) cp = {cp[14:0], window[pos + k][5:0]};
                take_point(cp);
                pos += span;
            end else if (fin) begin
                // The text ends inside a sequence: replace the lead, decode the rest again.
                take_point(CP_REPL);
                pos++;
            end else begin
                stuck = 1'b1;
            end
        end
        if (fin) begin
            if (held_ok) push_utf8(held_cp);
            clear_text();
        end else begin
            seq_fill = fill - pos;
            for (k = 0; k < 3; k++) begin
                if (k < seq_fill) seq_buf[k] = window[pos + k];
                else seq_buf[k] = 8'h00;
            end
        end
        foreach (step_q[i]) begin
            beat.data     = step_q[i];
            beat.run_last = (i == step_q.size() - 1);
            beat.text_end = fin && (i == step_q.size() - 1);
            owed_q.insert(owed_q.size(), beat);
        end
    endfunction

    function automatic void check_output();
        text_byte_t want;
        if (owed_q.size() == 0) begin
            if (fail_total < REPORT_LIMIT)
                $display("%0t ns: result %0d not expected: data %h run_last %b text_end %b",
                         $time, result_index, m_tdata, m_tlast, m_tuser);
            fail_total++;
        end else begin
            want = owed_q.pop_front();
            if (m_tdata !== want.data || m_tlast !== want.run_last ||
                m_tuser !== want.text_end) begin
                if (fail_total < REPORT_LIMIT)
                    $display({"%0t ns: result %0d mismatch: expected data %h run_last %b ",
                              "text_end %b, got data %h run_last %b text_end %b"},
                             $time, result_index, want.data, want.run_last, want.text_end,
                             m_tdata, m_tlast, m_tuser);
                fail_total++;
            end
        end
        result_index++;
    endfunction

    // Outputs are checked before the new input is predicted, so a stray result can
    // never be matched against an expectation created at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_text();
            owed_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_output();
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
        end
        mismatches <= fail_total;
        bytes_owed <= owed_q.size();
    end

endmodule

FILE: sim/korean_spacing_text_filter_test.sv
// Testbench top for the Korean spacing text filter: drives UTF-8 texts into the block
// with random idling on both channels and gives the verdict.
// Depends on kst_pkg, korean_spacing_text_filter and the kst_text_checker scoreboard.

module korean_spacing_text_filter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import kst_pkg::*;

    localparam int RESET_CYCLES     = 4;
    localparam int RANDOM_BYTES     = 88;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 10;
    localparam int TIMEOUT_NS       = 5_000_000;

    localparam cp_t SYLLABLE_FIRST = 21'h00AC00;
    localparam cp_t SYLLABLE_LAST  = 21'h00D7AF;
    localparam cp_t JAMO_FIRST     = 21'h001100;
    localparam cp_t JAMO_LAST      = 21'h0011FF;
    localparam cp_t COMPAT_FIRST   = 21'h003130;
    localparam cp_t COMPAT_LAST    = 21'h00318F;

    // Pieces that random texts are built from.
    typedef enum int {
        TOK_SYLLABLE,
        TOK_JAMO,
        TOK_COMPAT,
        TOK_BORDER,
        TOK_CLOSER,
        TOK_OPENER,
        TOK_SPACES,
        TOK_ASCII,
        TOK_TWO_BYTE,
        TOK_FOUR_BYTE,
        TOK_NOISE,
        TOK_CUT
    } token_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // in_byte
    logic       s_tlast  = 1'b0;    // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // out_byte
    logic       m_tlast;            // run_last
    logic       m_tuser;            // text_end

    int unsigned mismatches;
    int unsigned bytes_owed;

    // Set by the stimulus once it wants the receiver to back-pressure for a long stretch.
    logic hold_asked = 1'b0;

    // Bytes of the text being assembled.
    logic [7:0] text_q[$];

    always #5 aclk = ~aclk;

    korean_spacing_text_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    kst_text_checker text_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .bytes_owed (bytes_owed)
    );

    // Idle length shared by both sides: mostly none or short, now and then a long gap.
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Appends one byte to the text being assembled.
    function automatic void add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    // Shortest UTF-8 form; the stimulus only builds code points below U+10000 this way.
    function automatic void add_cp(input cp_t cp);
        if (cp < 21'h000080) begin
            add_byte(cp[7:0]);
        end else if (cp < 21'h000800) begin
            add_byte({TAG_LEAD2, cp[10:6]});
            add_byte({TAG_CONT, cp[5:0]});
        end else begin
            add_byte({TAG_LEAD3, cp[15:12]});
            add_byte({TAG_CONT, cp[11:6]});
            add_byte({TAG_CONT, cp[5:0]});
        end
    endfunction

    function automatic logic [7:0] random_lead(input int unsigned len);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        case (len)
            2:       b = {TAG_LEAD2, b[4:0]};
            3:       b = {TAG_LEAD3, b[3:0]};
            default: b = {TAG_LEAD4, b[2:0]};
        endcase
        return b;
    endfunction

    function automatic logic [7:0] random_cont();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return {TAG_CONT, b[5:0]};
    endfunction

    // Most of the weight goes to Korean text and the punctuation around it, so that the
    // spacing rules fire often; raw noise and cut-off sequences make up the rest.
    function automatic token_t pick_token();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 22) return TOK_SYLLABLE;
        if (r < 28) return TOK_JAMO;
        if (r < 34) return TOK_COMPAT;
        if (r < 40) return TOK_BORDER;
        if (r < 58) return TOK_CLOSER;
        if (r < 64) return TOK_OPENER;
        if (r < 74) return TOK_SPACES;
        if (r < 82) return TOK_ASCII;
        if (r < 86) return TOK_TWO_BYTE;
        if (r < 89) return TOK_FOUR_BYTE;
        if (r < 95) return TOK_NOISE;
        return TOK_CUT;
    endfunction

    function automatic void add_token(input token_t kind);
        cp_t         lo;
        cp_t         hi;
        int unsigned len;
        case (kind)
            TOK_SYLLABLE: add_cp(cp_t'(SYLLABLE_FIRST +
                                       $urandom_range(0, SYLLABLE_LAST - SYLLABLE_FIRST)));
            TOK_JAMO:     add_cp(cp_t'(JAMO_FIRST + $urandom_range(0, JAMO_LAST - JAMO_FIRST)));
            TOK_COMPAT:   add_cp(cp_t'(COMPAT_FIRST +
                                       $urandom_range(0, COMPAT_LAST - COMPAT_FIRST)));
            TOK_BORDER: begin
                // Just inside or just outside one of the Hangul ranges.
                case ($urandom_range(0, 2))
                    0: begin lo = SYLLABLE_FIRST; hi = SYLLABLE_LAST; end
                    1: begin lo = JAMO_FIRST;     hi = JAMO_LAST;     end
                    default: begin lo = COMPAT_FIRST; hi = COMPAT_LAST; end
                endcase
                case ($urandom_range(0, 3))
                    0:       add_cp(cp_t'(lo - 1));
                    1:       add_cp(lo);
                    2:       add_cp(hi);
                    default: add_cp(cp_t'(hi + 1));
                endcase
            end
            TOK_CLOSER: begin
                case ($urandom_range(0, 9))
                    0, 9: add_cp(CP_DOT);
                    1: begin
                        add_cp(CP_DOT);
                        add_cp(CP_DOT);
                    end
                    2:       add_cp(CP_BANG);
                    3:       add_cp(CP_QUEST);
                    4:       add_cp(CP_RBRACK);
                    5:       add_cp(CP_RPAREN);
                    6:       add_cp(CP_RBRACE);
                    7:       add_cp(CP_COLON);
                    default: add_cp(CP_STAR);
                endcase
            end
            TOK_OPENER: begin
                case ($urandom_range(0, 2))
                    0:       add_cp(CP_LBRACK);
                    1:       add_cp(CP_LPAREN);
                    default: add_cp(CP_LBRACE);
                endcase
            end
            TOK_SPACES:   repeat ($urandom_range(1, 4)) add_byte(BYTE_SPACE);
            TOK_ASCII:    add_byte(8'($urandom_range(0, 127)));
            TOK_TWO_BYTE: add_cp(cp_t'($urandom_range(21'h000080, 21'h0007FF)));
            TOK_FOUR_BYTE: begin
                // Any 4-byte form, values above U+10FFFF included.
                add_byte(random_lead(4));
                repeat (3) add_byte(random_cont());
            end
            TOK_NOISE:    add_byte(8'($urandom_range(0, 255)));
            default: begin
                // A lead with too few continuation bytes; whatever follows is swallowed
                // into the sequence, or the text ends inside it.
                len = $urandom_range(2, 4);
                add_byte(random_lead(len));
                repeat ($urandom_range(0, len - 2)) add_byte(random_cont());
            end
        endcase
    endfunction

    // One transaction on the input channel. Values change only at a rising edge, and
    // the valid line gets a single update per edge.
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic steady);
        int unsigned gap;
        gap = steady ? 0 : idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sends the assembled text with tlast on its final byte. About a quarter of the
    // texts go out back to back with no idling at all.
    task automatic send_text();
        logic steady;
        steady = ($urandom_range(0, 3) == 0);
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1, steady);
        text_q.delete();
    endtask

    // Stops offering and waits until every predicted result has been taken. The
    // scoreboard's count is registered, so it lags the queue; the loop waits for an
    // edge before it tests the count, so the count includes the last accepted byte.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (bytes_owed != 0);
    endtask

    // Receiver: runs of ready, random gaps, and once a long hold-off while the sender
    // keeps offering, so the block's output backs up and it stops taking input.
    initial begin : receiver
        int unsigned run;
        int unsigned idle;
        logic        long_hold_done;
        long_hold_done = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_asked && !long_hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_done = 1'b1;
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            idle = idle_cycles();
            if (idle > 0) begin
                m_tready <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int unsigned random_sent;
        logic        paused;
        random_sent = 0;
        paused      = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Spacing rules: a run of spaces, a two-dot ellipsis before a syllable (no
        // space), a single dot before a jamo (space), and a jamo before an opening
        // parenthesis (space); the final parenthesis is flushed with the end flag.
        repeat (2) add_byte(BYTE_SPACE);
        add_cp(CP_DOT);
        add_cp(CP_DOT);
        add_cp(SYLLABLE_FIRST);
        add_cp(CP_DOT);
        add_cp(JAMO_FIRST);
        add_cp(CP_LPAREN);
        send_text();

        // Decoding corners: the largest 4-byte value, an overlong NUL, a stray
        // continuation byte as lead, a real NUL, the all-ones byte, and a text that
        // ends inside a 3-byte sequence.
        add_byte({TAG_LEAD4, 3'b111});
        repeat (3) add_byte({TAG_CONT, 6'h3F});
        add_byte({TAG_LEAD2, 5'h00});
        add_byte({TAG_CONT, 6'h00});
        add_byte({TAG_CONT, 6'h00});
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte({TAG_LEAD3, 4'h1});
        add_byte({TAG_CONT, 6'h00});
        send_text();

        // Random texts of one to eight pieces each. The long receiver hold-off starts
        // now; halfway through, the sender pauses until the output has caught up.
        hold_asked = 1'b1;
        while (random_sent < RANDOM_BYTES) begin
            repeat ($urandom_range(1, 8)) add_token(pick_token());
            random_sent += text_q.size();
            send_text();
            if (!paused && random_sent >= RANDOM_BYTES / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && bytes_owed == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: a stuck handshake or a lost result ends the run here.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout after %0d ns", TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
